// ----- rtl/core/i2cac_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C target address claim package
// Beat payload types and protocol byte constants used by the target state
// machine.
// ----------------------------------------------------------------------------
package i2cac_pkg;

  // Bytes loaded into the shifter to answer a received byte.
  localparam logic [7:0] ACK_BYTE  = 8'h00;
  localparam logic [7:0] NACK_BYTE = 8'hFF;

  // General call commands.
  localparam logic [7:0] CMD_NEW_ADDR  = 8'h00;
  localparam logic [7:0] CMD_RESET_ALL = 8'h01;

  // Bit counts armed for the next shifter event.
  localparam logic [3:0] BITS_NONE   = 4'd0;
  localparam logic [3:0] BITS_ONE    = 4'd1;
  localparam logic [3:0] BITS_BUBBLE = 4'd7;
  localparam logic [3:0] BITS_BYTE   = 4'd8;

  // Register pointers below this value address the system bank.
  localparam logic [7:0] SYS_REG_LIMIT = 8'd2;

  // One shifter-complete event from the target port.
  typedef struct packed {
    logic       start_seen;
    logic       stop_seen;
    logic [7:0] shift_byte;
    logic       claim_won;
    logic [7:0] register_read_data;
  } event_t;

  // One result beat back to the port and register file.
  typedef struct packed {
    logic       drive_sda;
    logic       load_shifter;
    logic [7:0] shift_value;
    logic [3:0] next_bit_count;
    logic       release_clock;
    logic       register_write;
    logic [7:0] register_write_data;
    logic       register_read;
    logic       system_register;
    logic [7:0] register_pointer;
  } result_t;

endpackage

// ----- rtl/core/i2cac_stream_if.sv -----
// ----------------------------------------------------------------------------
// I2C target address claim stream interface
// Valid/ready channel that carries one payload beat per handshake.
// ----------------------------------------------------------------------------
interface i2cac_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/i2c_target_with_address_claim.sv -----
// ----------------------------------------------------------------------------
// I2C target byte state machine with address claiming
// Handles one shifter event per beat and answers with the shifter load, SDA
// direction, bit count and register strobes for the next bus phase.
// ----------------------------------------------------------------------------
// Each accepted event beat is handled by one state update: the protocol state
// is updated at the accepting edge and the result beat appears in the output
// register on the next cycle. A new event is taken every cycle as long as the
// output register is empty or its beat is taken in the same cycle, so the
// sustained rate is one event per clock. The block answers address bytes for
// its own address and the general call address, receives register pointer
// and data bytes, transmits register bytes until the controller NACKs, and
// handles general call command 0 (claim a new address after a bubble and
// arbitration) and command 1 (drop the own address). The own address is zero,
// meaning unassigned, after reset.
// ----------------------------------------------------------------------------
module i2c_target_with_address_claim (
  input logic                                      clk,
  input logic                                      rst,
  i2cac_stream_if.sink                             evt,
  i2cac_stream_if.source                           res
);
  import i2cac_pkg::*;

  // Protocol state codes.
  localparam logic [3:0] ST_IDLE        = 4'd0;
  localparam logic [3:0] ST_START       = 4'd1;
  localparam logic [3:0] ST_ADDR        = 4'd2;
  localparam logic [3:0] ST_RX          = 4'd3;
  localparam logic [3:0] ST_HANDLE_RX   = 4'd4;
  localparam logic [3:0] ST_BUBBLE      = 4'd5;
  localparam logic [3:0] ST_GLOBAL      = 4'd6;
  localparam logic [3:0] ST_READ_STOP   = 4'd7;
  localparam logic [3:0] ST_TX          = 4'd8;
  localparam logic [3:0] ST_RX_NACK     = 4'd9;
  localparam logic [3:0] ST_HANDLE_NACK = 4'd10;
  localparam logic [3:0] ST_RESET       = 4'd11;

  // Protocol state.
  logic [3:0] protocol_state, protocol_state_next;
  logic [6:0] own_address, own_address_next;
  logic       general_call_flag, general_call_flag_next;
  logic [7:0] byte_counter, byte_counter_next;
  logic [7:0] command_byte, command_byte_next;
  logic [7:0] pending_address, pending_address_next;
  logic       bubble_pending, bubble_pending_next;
  logic [7:0] pointer_register, pointer_register_next;
  logic       sda_drive, sda_drive_next;

  // Output register.
  logic    res_valid;
  result_t res_data, res_data_next;

  logic       acc;
  logic [3:0] cur_state;
  logic [6:0] addr7;
  logic [7:0] cmd_eff;

  assign evt.ready = !res_valid || res.ready;
  assign acc       = evt.valid && evt.ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  // Next state and result for the event on the input channel.
  always_comb begin
    protocol_state_next    = protocol_state;
    own_address_next       = own_address;
    general_call_flag_next = general_call_flag;
    byte_counter_next      = byte_counter;
    command_byte_next      = command_byte;
    pending_address_next   = pending_address;
    bubble_pending_next    = bubble_pending;
    pointer_register_next  = pointer_register;
    sda_drive_next         = sda_drive;
    res_data_next          = '0;
    addr7                  = evt.data.shift_byte[7:1];
    cmd_eff                = command_byte;

    // A start condition restarts the sequence before the event is handled.
    cur_state = evt.data.start_seen ? ST_START : protocol_state;

    case (cur_state)
      ST_START: begin
        res_data_next.next_bit_count = BITS_BYTE;
        protocol_state_next          = ST_ADDR;
      end
      ST_ADDR: begin
        res_data_next.load_shifter   = 1'b1;
        res_data_next.next_bit_count = BITS_ONE;
        if (addr7 == 7'd0 || addr7 == own_address) begin
          byte_counter_next          = 8'd0;
          general_call_flag_next     = (evt.data.shift_byte == 8'd0);
          protocol_state_next        = evt.data.shift_byte[0] ? ST_TX : ST_RX;
          sda_drive_next             = 1'b1;
          res_data_next.shift_value  = ACK_BYTE;
        end else begin
          res_data_next.release_clock = 1'b1;
          protocol_state_next         = ST_RESET;
          sda_drive_next              = 1'b0;
          res_data_next.shift_value   = NACK_BYTE;
        end
      end
      ST_READ_STOP, ST_RX: begin
        if (cur_state == ST_READ_STOP && evt.data.stop_seen) begin
          sda_drive_next      = 1'b0;
          protocol_state_next = ST_IDLE;
        end else begin
          sda_drive_next               = 1'b0;
          res_data_next.next_bit_count = BITS_BYTE;
          protocol_state_next          = general_call_flag ? ST_GLOBAL : ST_HANDLE_RX;
        end
      end
      ST_HANDLE_RX: begin
        byte_counter_next = byte_counter + 8'd1;
        if (byte_counter_next == 8'd1) begin
          pointer_register_next = evt.data.shift_byte;
        end else begin
          res_data_next.register_write      = 1'b1;
          res_data_next.register_write_data = evt.data.shift_byte;
        end
        protocol_state_next          = ST_READ_STOP;
        sda_drive_next               = 1'b1;
        res_data_next.load_shifter   = 1'b1;
        res_data_next.shift_value    = ACK_BYTE;
        res_data_next.next_bit_count = BITS_ONE;
      end
      ST_BUBBLE: begin
        if (bubble_pending) begin
          sda_drive_next               = 1'b0;
          res_data_next.next_bit_count = BITS_BUBBLE;
          protocol_state_next          = ST_GLOBAL;
          bubble_pending_next          = 1'b0;
        end else begin
          sda_drive_next               = 1'b1;
          res_data_next.load_shifter   = 1'b1;
          res_data_next.shift_value    = ACK_BYTE;
          res_data_next.next_bit_count = BITS_ONE;
          protocol_state_next          = ST_RESET;
        end
      end
      ST_GLOBAL: begin
        // General call payload: the first byte is the command.
        byte_counter_next = byte_counter + 8'd1;
        if (byte_counter_next == 8'd1) begin
          cmd_eff = evt.data.shift_byte;
        end
        command_byte_next = cmd_eff;
        if (cmd_eff == CMD_NEW_ADDR) begin
          if (own_address != 7'd0) begin
            sda_drive_next               = 1'b0;
            res_data_next.load_shifter   = 1'b1;
            res_data_next.shift_value    = NACK_BYTE;
            res_data_next.next_bit_count = BITS_ONE;
            protocol_state_next          = ST_RESET;
          end else if (byte_counter_next == 8'd1) begin
            sda_drive_next               = 1'b1;
            res_data_next.load_shifter   = 1'b1;
            res_data_next.shift_value    = ACK_BYTE;
            res_data_next.next_bit_count = BITS_ONE;
            protocol_state_next          = ST_RX;
          end else if (byte_counter_next == 8'd2) begin
            pending_address_next         = evt.data.shift_byte;
            sda_drive_next               = 1'b1;
            res_data_next.load_shifter   = 1'b1;
            res_data_next.shift_value    = ACK_BYTE;
            res_data_next.next_bit_count = BITS_ONE;
            bubble_pending_next          = 1'b1;
            protocol_state_next          = ST_BUBBLE;
          end else if (byte_counter_next == 8'd3) begin
            // Arbitration decides the claim; SDA stays released to read
            // the last bubble bit.
            if (evt.data.claim_won) begin
              own_address_next          = pending_address[6:0];
              res_data_next.shift_value = ACK_BYTE;
            end else begin
              res_data_next.shift_value = NACK_BYTE;
            end
            res_data_next.load_shifter   = 1'b1;
            sda_drive_next               = 1'b0;
            res_data_next.next_bit_count = BITS_ONE;
            protocol_state_next          = ST_BUBBLE;
          end
        end else if (cmd_eff == CMD_RESET_ALL) begin
          own_address_next             = 7'd0;
          sda_drive_next               = 1'b1;
          res_data_next.load_shifter   = 1'b1;
          res_data_next.shift_value    = ACK_BYTE;
          res_data_next.next_bit_count = BITS_ONE;
          protocol_state_next          = ST_RESET;
        end
      end
      ST_HANDLE_NACK, ST_TX: begin
        if (cur_state == ST_HANDLE_NACK && evt.data.shift_byte[0]) begin
          sda_drive_next      = 1'b0;
          protocol_state_next = ST_IDLE;
        end else begin
          sda_drive_next               = 1'b1;
          res_data_next.load_shifter   = 1'b1;
          res_data_next.shift_value    = evt.data.register_read_data;
          res_data_next.register_read  = 1'b1;
          res_data_next.next_bit_count = BITS_BYTE;
          protocol_state_next          = ST_RX_NACK;
        end
      end
      ST_RX_NACK: begin
        sda_drive_next               = 1'b0;
        res_data_next.next_bit_count = BITS_ONE;
        protocol_state_next          = ST_HANDLE_NACK;
      end
      ST_RESET: begin
        sda_drive_next      = 1'b0;
        protocol_state_next = ST_IDLE;
      end
      default: begin
        protocol_state_next = ST_IDLE;
      end
    endcase

    res_data_next.drive_sda        = sda_drive_next;
    res_data_next.register_pointer = pointer_register_next;
    res_data_next.system_register  = (pointer_register_next < SYS_REG_LIMIT);
  end

  // State update on each accepted event beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_state    <= ST_IDLE;
      own_address       <= '0;
      general_call_flag <= 1'b0;
      byte_counter      <= '0;
      command_byte      <= '0;
      pending_address   <= '0;
      bubble_pending    <= 1'b0;
      pointer_register  <= '0;
      sda_drive         <= 1'b0;
    end else if (acc) begin
      protocol_state    <= protocol_state_next;
      own_address       <= own_address_next;
      general_call_flag <= general_call_flag_next;
      byte_counter      <= byte_counter_next;
      command_byte      <= command_byte_next;
      pending_address   <= pending_address_next;
      bubble_pending    <= bubble_pending_next;
      pointer_register  <= pointer_register_next;
      sda_drive         <= sda_drive_next;
    end
  end

  // Result register: filled on accept, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (acc) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_data <= res_data_next;
    end
  end

  // Every accepted event leaves a result beat waiting.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> res_valid)
    else $error("accepted event produced no result beat");

  // The own address only changes on an accepted event.
  a_addr_stable: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(own_address))
    else $error("own address changed without an event");

  // Register write and read strobes never come in the same beat.
  a_strobe_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.register_write && res_data.register_read))
    else $error("register write and read strobes together");

  // A beat with no shifter load carries a zero value.
  a_no_load_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.load_shifter) |-> (res_data.shift_value == 8'd0))
    else $error("shift value set without a load");

  // The reported pointer is the stored pointer.
  a_pointer_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.register_pointer == pointer_register))
    else $error("reported register pointer differs from stored pointer");

endmodule
